[design/acbe_pkg.sv]
// Package for the constant-color block encoder: shared types and constants.
// It depends on nothing; the controller, the datapath and the top level import it.
package acbe_pkg;

   // Fixed limits of the block.
   localparam int unsigned MAX_IMAGE_DIM = 16384;
   localparam int unsigned MIN_TILE_SIDE = 4;
   localparam int unsigned MAX_TILE_SIDE = 12;
   localparam int unsigned SUM_COLUMNS   = MAX_IMAGE_DIM / MIN_TILE_SIDE;
   localparam int unsigned COL_W         = $clog2(SUM_COLUMNS);

   // Widths of the counters and of the divider.
   localparam int unsigned DIM_W      = 15;
   localparam int unsigned PIX_W      = 14;
   localparam int unsigned SIDE_W     = 4;
   localparam int unsigned SUM_W      = 16;
   localparam int unsigned COUNT_W    = 9;
   localparam int unsigned DIV_STEPS  = SUM_W;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
   localparam int unsigned CHANNELS   = 4;

   // Void-extent LDR header: mode bits, reserved bits and all-ones extents.
   localparam logic [63:0] VOID_EXTENT_LOW = 64'hFFFF_FFFF_FFFF_FDFC;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_WIDTH   = 2'd2;
   localparam logic [1:0] CSR_TILE_HEIGHT  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // take the input word and read its column sums
      logic update;    // write the new sums and load the divider
      logic div_step;  // one quotient bit for all four channels
      logic publish;   // move the finished block into the output register
   } acbe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic closing;   // the accepted pixel closes its tile
      logic out_free;  // the output register can take a block this cycle
   } acbe_status_type;

endpackage

[design/acbe_controller.sv]
// Controller of the constant-color block encoder: sequences one pixel at a time.
// Depends on acbe_pkg for the command and status types.
module acbe_controller
   import acbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  acbe_status_type status,
   output acbe_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            step_in    = '0;
            state_in   = status.closing ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[design/acbe_datapath.sv]
// Datapath of the constant-color block encoder: registers, counters, the
// column-sum memory, a four-lane restoring divider and the output register.
// Depends on acbe_pkg for constants and the command and status types.
module acbe_datapath
   import acbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_write_data,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   input  logic [7:0]       req_alpha,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_block_low,
   output logic [63:0]      rsp_block_high,
   output logic             rsp_last_block,
   input  acbe_cmd_type     cmd,
   output acbe_status_type  status
);

   // Configuration registers.
   logic [DIM_W-1:0]  image_width_ff, image_height_ff;
   logic [SIDE_W-1:0] tile_width_ff, tile_height_ff;

   // Position counters.
   logic [PIX_W-1:0]  pixel_column_ff, pixel_column_in;
   logic [PIX_W-1:0]  pixel_row_ff, pixel_row_in;
   logic [SIDE_W-1:0] column_in_tile_ff, column_in_tile_in;
   logic [SIDE_W-1:0] row_in_tile_ff, row_in_tile_in;
   logic [COL_W-1:0]  tile_column_ff, tile_column_in;

   // Per-pixel captured values.
   logic [7:0]         pixel_ff [CHANNELS];
   logic               first_ff, closing_ff, last_ff;
   logic [COL_W-1:0]   col_ff;
   logic [COUNT_W-1:0] count_ff;

   // Column-sum memory, four 16-bit sums per entry.
   logic [CHANNELS*SUM_W-1:0] sums_mem [SUM_COLUMNS];
   logic [CHANNELS*SUM_W-1:0] rd_data_ff;
   logic [CHANNELS*SUM_W-1:0] new_sum;

   // Divider lanes.
   logic [SUM_W-1:0]   quo_ff [CHANNELS];
   logic [COUNT_W-1:0] rem_ff [CHANNELS];

   // Output register.
   logic        rsp_valid_ff;
   logic [63:0] block_high_ff;
   logic        last_block_ff;

   logic [DIM_W-1:0]  width_eff, height_eff, width_m1, height_m1;
   logic [SIDE_W-1:0] tile_w_eff, tile_h_eff, tile_w_m1, tile_h_m1;
   logic              row_end, image_bottom, tile_right, tile_bottom, col_wrap;
   logic [SIDE_W:0]   cols_done, rows_done;
   logic [7:0]        pixel_in [CHANNELS];

   assign pixel_in[0] = req_red;
   assign pixel_in[1] = req_green;
   assign pixel_in[2] = req_blue;
   assign pixel_in[3] = req_alpha;

   // Effective geometry: zero image sizes act as one, large ones saturate, and tile sides outside 4..12 act as 4.
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (image_width_ff > DIM_W'(MAX_IMAGE_DIM)) begin
         width_eff = DIM_W'(MAX_IMAGE_DIM);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = DIM_W'(1);
      end else if (image_height_ff > DIM_W'(MAX_IMAGE_DIM)) begin
         height_eff = DIM_W'(MAX_IMAGE_DIM);
      end else begin
         height_eff = image_height_ff;
      end
      if (tile_width_ff < SIDE_W'(MIN_TILE_SIDE) || tile_width_ff > SIDE_W'(MAX_TILE_SIDE)) begin
         tile_w_eff = SIDE_W'(MIN_TILE_SIDE);
      end else begin
         tile_w_eff = tile_width_ff;
      end
      if (tile_height_ff < SIDE_W'(MIN_TILE_SIDE) || tile_height_ff > SIDE_W'(MAX_TILE_SIDE)) begin
         tile_h_eff = SIDE_W'(MIN_TILE_SIDE);
      end else begin
         tile_h_eff = tile_height_ff;
      end
   end

   assign width_m1     = width_eff - 1'b1;
   assign height_m1    = height_eff - 1'b1;
   assign tile_w_m1    = tile_w_eff - 1'b1;
   assign tile_h_m1    = tile_h_eff - 1'b1;
   assign row_end      = {1'b0, pixel_column_ff} >= width_m1;
   assign image_bottom = {1'b0, pixel_row_ff} >= height_m1;
   assign col_wrap     = column_in_tile_ff >= tile_w_m1;
   assign tile_right   = col_wrap || row_end;
   assign tile_bottom  = (row_in_tile_ff >= tile_h_m1) || image_bottom;
   assign cols_done    = {1'b0, column_in_tile_ff} + 1'b1;
   assign rows_done    = {1'b0, row_in_tile_ff} + 1'b1;

   // Counter advance for one accepted pixel.
   always_comb begin
      pixel_column_in   = pixel_column_ff + 1'b1;
      pixel_row_in      = pixel_row_ff;
      column_in_tile_in = column_in_tile_ff + 1'b1;
      row_in_tile_in    = row_in_tile_ff;
      tile_column_in    = tile_column_ff;
      if (row_end) begin
         pixel_column_in   = '0;
         column_in_tile_in = '0;
         tile_column_in    = '0;
         row_in_tile_in    = tile_bottom ? '0 : row_in_tile_ff + 1'b1;
         pixel_row_in      = image_bottom ? '0 : pixel_row_ff + 1'b1;
      end else if (col_wrap) begin
         column_in_tile_in = '0;
         tile_column_in    = tile_column_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= DIM_W'(1);
         image_height_ff   <= DIM_W'(1);
         tile_width_ff     <= SIDE_W'(MIN_TILE_SIDE);
         tile_height_ff    <= SIDE_W'(MIN_TILE_SIDE);
         pixel_column_ff   <= '0;
         pixel_row_ff      <= '0;
         column_in_tile_ff <= '0;
         row_in_tile_ff    <= '0;
         tile_column_ff    <= '0;
         closing_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
               CSR_TILE_WIDTH:   tile_width_ff   <= csr_write_data[SIDE_W-1:0];
               CSR_TILE_HEIGHT:  tile_height_ff  <= csr_write_data[SIDE_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            pixel_column_ff   <= pixel_column_in;
            pixel_row_ff      <= pixel_row_in;
            column_in_tile_ff <= column_in_tile_in;
            row_in_tile_ff    <= row_in_tile_in;
            tile_column_ff    <= tile_column_in;
            closing_ff        <= tile_right && tile_bottom;
         end
      end
   end

   // Captured pixel and its tile bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pixel_ff[c] <= pixel_in[c];
         end
         first_ff <= (row_in_tile_ff == '0) && (column_in_tile_ff == '0);
         last_ff  <= row_end && image_bottom;
         col_ff   <= tile_column_ff;
         count_ff <= {4'd0, cols_done} * {4'd0, rows_done};
      end
   end

   // The first pixel of a tile overwrites the sums; later ones add with wrap.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (first_ff) begin
            new_sum[c*SUM_W +: SUM_W] = {8'd0, pixel_ff[c]};
         end else begin
            new_sum[c*SUM_W +: SUM_W] = rd_data_ff[c*SUM_W +: SUM_W] + {8'd0, pixel_ff[c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_data_ff <= sums_mem[tile_column_ff];
      end
      if (cmd.update) begin
         sums_mem[col_ff] <= new_sum;
      end
   end

   // Restoring division, one quotient bit per lane and cycle.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         logic [COUNT_W:0] rem_sh;
         logic [COUNT_W:0] rem_sub;
         rem_sh  = {rem_ff[c], quo_ff[c][SUM_W-1]};
         rem_sub = rem_sh - {1'b0, count_ff};
         if (cmd.update) begin
            quo_ff[c] <= new_sum[c*SUM_W +: SUM_W];
            rem_ff[c] <= '0;
         end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, count_ff}) begin
               rem_ff[c] <= rem_sub[COUNT_W-1:0];
               quo_ff[c] <= {quo_ff[c][SUM_W-2:0], 1'b1};
            end else begin
               rem_ff[c] <= rem_sh[COUNT_W-1:0];
               quo_ff[c] <= {quo_ff[c][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   // Output register; the low byte of each quotient is replicated to 16 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         for (int c = 0; c < CHANNELS; c++) begin
            block_high_ff[c*SUM_W +: SUM_W] <= {quo_ff[c][7:0], quo_ff[c][7:0]};
         end
         last_block_ff <= last_ff;
      end
   end

   assign status.closing  = closing_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_low  = VOID_EXTENT_LOW;
   assign rsp_block_high = block_high_ff;
   assign rsp_last_block = last_block_ff;

endmodule

[design/astc_constant_color_block_encoder_core.sv]
// Top level of the constant-color block encoder: a controller and a datapath.
// Depends on acbe_pkg, acbe_controller and acbe_datapath.
//
// This block takes RGBA pixels in raster order, one word per pixel, and emits
// one 128-bit void-extent LDR block for every image tile, in block raster
// order, as the last pixel of that tile arrives. Each channel is averaged over
// the pixels of the tile that lie inside the image and the average byte is
// replicated into a 16-bit value. Pixels are handled one at a time: a pixel
// that does not close a tile takes a read and a write of its column's sums in
// a single-port memory of 4096 entries, and a pixel that closes a tile takes
// the same read and write, 16 steps of a restoring divider shared by the four
// channels and a load of the output register, which waits while a previous
// block still sits unclaimed there. A finished block waits in the output
// register, so the next pixel is taken while the downstream side stalls. The
// column-sum memory needs no clearing after reset, because the first pixel of
// every tile overwrites its entry. Configuration is written through the csr
// port while the block is idle; the user must keep to this, as the block does
// not enforce it. The image is restarted at its top-left corner after the
// last pixel of each image.
module astc_constant_color_block_encoder_core
   import acbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   input  logic [7:0]       req_alpha,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_block_low,
   output logic [63:0]      rsp_block_high,
   output logic             rsp_last_block
);

   acbe_cmd_type    cmd;
   acbe_status_type status;

   // The controller sequences accept, update, divide and publish.
   acbe_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the counters, the sums, the divider and the output.
   acbe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_block_low    (rsp_block_low),
      .rsp_block_high   (rsp_block_high),
      .rsp_last_block   (rsp_last_block),
      .cmd              (cmd),
      .status           (status)
   );

   // An accepted pixel is always written back in the following cycle.
   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.update)
      else $error("accepted pixel was not written back");

   // A pixel that does not close a tile frees the input right after its write.
   a_open_pixel_returns: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !status.closing) |=> !req_stall)
      else $error("input stayed stalled after a non-closing pixel");

   // A block is never loaded over one that is still stalled at the output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || !rsp_stall))
      else $error("output block overwritten while stalled");

   // The divider only runs while the input side is held off.
   a_divide_stalls_input: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> req_stall)
      else $error("divider stepping while input is open");

endmodule

[bench/testbench.sv]
// Self-checking bench for the constant-color block encoder core.
// It needs acbe_pkg and the core; a built-in block predictor checks every output word.
`timescale 1ns / 1ps

module testbench;
   import acbe_pkg::*;

   // Settling time after the last expected block, with margin enough to cover
   // any work still in flight.
   localparam int SETTLE_CYCLES = 48;
   localparam int SUM_ENTRIES   = 4096;
   localparam int MAX_WAIT      = 17;
   localparam int RANDOM_PIXELS = 460;
   localparam int REPORT_LINES  = 40;
   // Every block carries the same void-extent header word.
   localparam logic [63:0] HEADER_WORD = 64'hFFFF_FFFF_FFFF_FDFC;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [63:0] header;
      logic [63:0] colors;
      logic        closes_image;
   } block_type;

   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_WHITE, FILL_BLACK} fill_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [1:0]       csr_index = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0] csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_red = 8'd0;
   logic [7:0]       req_green = 8'd0;
   logic [7:0]       req_blue = 8'd0;
   logic [7:0]       req_alpha = 8'd0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [63:0]      rsp_block_low;
   logic [63:0]      rsp_block_high;
   logic             rsp_last_block;

   astc_constant_color_block_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_block_low    (rsp_block_low),
      .rsp_block_high   (rsp_block_high),
      .rsp_last_block   (rsp_last_block)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Copies of the configuration registers, holding their reset values until
   // the bench writes them.
   logic [14:0] image_width_reg  = 15'd1;
   logic [14:0] image_height_reg = 15'd1;
   logic [3:0]  tile_width_reg   = 4'd4;
   logic [3:0]  tile_height_reg  = 4'd4;

   // Predictor state: the raster position, the position inside the current
   // tile, and the running channel sums for each tile column.
   logic [13:0]       at_column   = '0;
   logic [13:0]       at_row      = '0;
   logic [3:0]        col_in_tile = '0;
   logic [3:0]        row_in_tile = '0;
   logic [11:0]       tile_index  = '0;
   logic [3:0][15:0]  channel_sums [SUM_ENTRIES];

   // Blocks that the accepted pixels are known to produce, oldest first.
   block_type expected_blocks[$];
   block_type oldest_block;

   int  error_count = 0;
   int  pixels_sent = 0;
   int  rsp_hold    = 0;
   // When clear, that side of the handshake never idles.
   bit  req_idle_on = 1'b0;
   bit  rsp_idle_on = 1'b0;

   // Width and height of zero behave as one; anything past the largest
   // supported image saturates.
   function automatic int unsigned effective_dim(input logic [14:0] v);
      if (v == 15'd0) return 1;
      if (v > 15'd16384) return 16384;
      return 32'(v);
   endfunction

   // Tile sides outside 4..12 fall back to 4.
   function automatic int unsigned effective_side(input logic [3:0] v);
      if (v < 4'd4 || v > 4'd12) return 4;
      return 32'(v);
   endfunction

   function automatic int draw_wait(input bit enabled);
      if (!enabled) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic pixel_type make_pixel(input fill_kind_type kind);
      pixel_type px;
      case (kind)
         FILL_WHITE: px = '1;
         FILL_BLACK: px = '0;
         FILL_EXTREME: begin
            px.red   = {8{1'($urandom_range(0, 1))}};
            px.green = {8{1'($urandom_range(0, 1))}};
            px.blue  = {8{1'($urandom_range(0, 1))}};
            px.alpha = {8{1'($urandom_range(0, 1))}};
         end
         default: px = $urandom();
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < REPORT_LINES) $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // Advance the predictor by one accepted pixel. The first pixel of a tile
   // replaces its column's sums, every other pixel adds to them. When the
   // pixel closes its tile (right edge of the tile or of the image, on the
   // tile's last row or the image's last row) the block is queued.
   function automatic void predict_block(input pixel_type px);
      int unsigned w, h, tw, th, count;
      bit          row_end, bottom_row, tile_right, tile_bottom;
      logic [7:0]  chan [4];
      logic [7:0]  avg;
      block_type   blk;
      w  = effective_dim(image_width_reg);
      h  = effective_dim(image_height_reg);
      tw = effective_side(tile_width_reg);
      th = effective_side(tile_height_reg);
      row_end     = at_column >= w - 1;
      bottom_row  = at_row >= h - 1;
      tile_right  = col_in_tile >= tw - 1 || row_end;
      tile_bottom = row_in_tile >= th - 1 || bottom_row;
      chan = '{px.red, px.green, px.blue, px.alpha};

      for (int c = 0; c < 4; c++) begin
         if (row_in_tile == 4'd0 && col_in_tile == 4'd0)
            channel_sums[tile_index][c] = {8'd0, chan[c]};
         else
            channel_sums[tile_index][c] = channel_sums[tile_index][c] + {8'd0, chan[c]};
      end

      if (tile_right && tile_bottom) begin
         // Only the pixels inside the image count, so edge tiles divide by less.
         count = (col_in_tile + 1) * (row_in_tile + 1);
         blk.header = HEADER_WORD;
         blk.colors = '0;
         for (int c = 0; c < 4; c++) begin
            avg = 8'(channel_sums[tile_index][c] / count);
            blk.colors[16*c +: 16] = {avg, avg};
         end
         blk.closes_image = row_end && bottom_row;
         expected_blocks.push_back(blk);
      end

      if (row_end) begin
         at_column   = '0;
         col_in_tile = '0;
         tile_index  = '0;
         row_in_tile = tile_bottom ? 4'd0 : row_in_tile + 4'd1;
         at_row      = bottom_row ? 14'd0 : at_row + 14'd1;
      end else begin
         at_column = at_column + 14'd1;
         if (col_in_tile >= tw - 1) begin
            col_in_tile = '0;
            tile_index  = tile_index + 12'd1;
         end else begin
            col_in_tile = col_in_tile + 4'd1;
         end
      end
   endfunction

   // Present one pixel word and hold it until the core takes it. The valid
   // line is only dropped when a gap is drawn, so back-to-back words keep it
   // high. Called and returning right after a rising edge.
   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = draw_wait(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= px.red;
      req_green <= px.green;
      req_blue  <= px.blue;
      req_alpha <= px.alpha;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_block(px);
      pixels_sent++;
   endtask

   // Drop valid and wait until every expected block has come out, then give
   // the core time to finish anything that produces no block.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers while the core is idle. The tile registers get
   // random junk above their four bits, which the core has to ignore.
   task automatic set_geometry(input logic [14:0] w, input logic [14:0] h,
                               input logic [3:0] tw, input logic [3:0] th);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      csr_index      <= CSR_IMAGE_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_index      <= CSR_TILE_WIDTH;
      csr_write_data <= {11'($urandom()), tw};
      @(posedge clock);
      csr_index      <= CSR_TILE_HEIGHT;
      csr_write_data <= {11'($urandom()), th};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      image_width_reg  = w;
      image_height_reg = h;
      tile_width_reg   = tw;
      tile_height_reg  = th;
   endtask

   // One whole image under the current geometry, so the raster position is
   // back at the top-left corner afterwards.
   task automatic send_image(input fill_kind_type kind);
      int unsigned total;
      total = effective_dim(image_width_reg) * effective_dim(image_height_reg);
      for (int unsigned i = 0; i < total; i++) send_pixel(make_pixel(kind));
   endtask

   // Output side: every accepted block is compared with the oldest expected
   // one. After each accepted word a fresh stall length is drawn, and stall
   // is held for that many cycles whether or not a block is waiting.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch($sformatf("unexpected block high=%h", rsp_block_high));
            end else begin
               oldest_block = expected_blocks.pop_front();
               if (rsp_block_low !== oldest_block.header)
                  report_mismatch($sformatf("block_low %h, wanted %h",
                                            rsp_block_low, oldest_block.header));
               if (rsp_block_high !== oldest_block.colors)
                  report_mismatch($sformatf("block_high %h, wanted %h",
                                            rsp_block_high, oldest_block.colors));
               if (rsp_last_block !== oldest_block.closes_image)
                  report_mismatch($sformatf("last_block %b, wanted %b",
                                            rsp_last_block, oldest_block.closes_image));
            end
            rsp_hold = draw_wait(rsp_idle_on);
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Out of reset the geometry is a 1x1 image with 4x4 tiles, so every
   // pixel is a block of its own and also the last block of its image.
   task automatic test_reset_geometry();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_pixel(make_pixel(FILL_BLACK));
      send_pixel(make_pixel(FILL_WHITE));
      send_pixel(make_pixel(FILL_EXTREME));
      send_pixel(make_pixel(FILL_RANDOM));
   endtask

   // Zero width and height act as one; a zero tile side acts as four.
   task automatic test_zero_dimensions();
      set_geometry(15'd0, 15'd0, 4'd0, 4'd0);
      send_image(FILL_WHITE);
      send_image(FILL_RANDOM);
   endtask

   // A 5x3 image with 4x4 tiles: a 4x3 tile and a clipped 1x3 tile on the
   // right, both cut short at the bottom, so neither divides by a power of two.
   task automatic test_clipped_tiles();
      set_geometry(15'd5, 15'd3, 4'd4, 4'd4);
      send_image(FILL_RANDOM);
   endtask

   // The largest tile full of white pixels gives the largest sum there is.
   task automatic test_full_tile_sum();
      set_geometry(15'd12, 15'd12, 4'd12, 4'd12);
      send_image(FILL_WHITE);
   endtask

   // A long single row with both tile codes out of range, so the tiles fall
   // back to four wide and the row walks through many column-sum entries
   // with no idle cycles on either side.
   task automatic test_long_row();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_geometry(15'd300, 15'd1, 4'd0, 4'd15);
      send_image(FILL_RANDOM);
   endtask

   // A tall image, one pixel wide, with an over-range tile width.
   task automatic test_tall_column();
      set_geometry(15'd1, 15'd300, 4'd13, 4'd12);
      send_image(FILL_RANDOM);
   endtask

   // Whole small images with random geometry, contents and handshake
   // pressure. Now and then the width is zero or past a few tiles, and the
   // tile sides cover every register value, legal or not.
   task automatic test_random_images();
      int            start, pick, hmax;
      logic [14:0]   w, h;
      fill_kind_type kind;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) w = 15'($urandom_range(0, 80));
         else w = 15'($urandom_range(1, 24));
         hmax = 160 / effective_dim(w);
         if (hmax < 1) hmax = 1;
         if (hmax > 20) hmax = 20;
         if ($urandom_range(0, 9) == 0) h = 15'd0;
         else h = 15'($urandom_range(1, hmax));
         set_geometry(w, h, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 9);
         if (pick < 7) kind = FILL_RANDOM;
         else if (pick == 7) kind = FILL_EXTREME;
         else if (pick == 8) kind = FILL_WHITE;
         else kind = FILL_BLACK;
         send_image(kind);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_zero_dimensions();
      test_clipped_tiles();
      test_full_tile_sum();
      test_long_row();
      test_tall_column();
      test_random_images();
      wait_quiet();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Hard stop, several times the slowest legal run.
   initial begin
      #48_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
